// File: hdl/pasr_pkg.sv
// Shared constants and types for the phase accumulator and sliding-window RMS meter.
package pasr_pkg;

   localparam int SAMPLE_W    = 16;  // signed input sample
   localparam int PHASE_OUT_W = 32;  // phase field on the result channel
   localparam int INC_W       = 32;  // frequency word
   localparam int RMS_W       = 16;  // rms field on the result channel
   localparam int SQ_W        = 31;  // one stored square, 2^30 max
   // shared subtractor: holds the sum and WINDOW * trial term, window up to 1024
   localparam int SUB_W       = 43;
   localparam int ROOT_STEPS  = 16;  // result bit pairs of the square root

   typedef struct packed {
      logic [SUB_W-1:0] diff;
      logic             borrow;  // set when a < b
   } sub_result_type;

endpackage

// File: hdl/pasr_req_if.sv
// Request channel: one voltage sample per control tick.
interface pasr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pasr_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// File: hdl/pasr_rsp_if.sv
// Response channel: phase and rms value for each request.
interface pasr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pasr_pkg::PHASE_OUT_W-1:0] phase;
   logic [pasr_pkg::RMS_W-1:0]       rms_value;

   modport source (output valid, output phase, output rms_value, input ready);
   modport sink   (input valid, input phase, input rms_value, output ready);
endinterface

// File: hdl/pasr_sub_unit.sv
// Shared compare/subtract unit, time-shared by the square-root steps.
module pasr_sub_unit (
   input  logic [pasr_pkg::SUB_W-1:0] a,
   input  logic [pasr_pkg::SUB_W-1:0] b,
   output pasr_pkg::sub_result_type    result
);

   logic [pasr_pkg::SUB_W:0] wide;

   assign wide          = {1'b0, a} - {1'b0, b};
   assign result.diff   = wide[pasr_pkg::SUB_W-1:0];
   assign result.borrow = wide[pasr_pkg::SUB_W];

endmodule

// File: hdl/phase_accumulator_sliding_rms.sv
// Top level: phase accumulator with sliding-window RMS meter.
//
// Each request carries one signed 16-bit voltage sample. The block adds the
// frequency word (csr_wr_data, to be written only while idle; not enforced by
// the block) to a wrapping phase accumulator, squares the sample, swaps it
// into a WINDOW-deep ring of squares kept in a single-port-write /
// registered-read memory, and keeps the exact running sum. The response
// carries the new phase (low 32 bits) and floor(sqrt(floor(sum / WINDOW))).
// No divider is needed: that root is the largest r with WINDOW * r^2 <= sum,
// so a bit-pair square root runs straight on the sum with every trial term
// scaled by WINDOW, one result bit per cycle on one time-shared subtractor.
// A request therefore passes through the accept, ring read and ring update
// states, 16 root steps and a state that loads the response register once
// the previous response has left it. req_chan.ready is low from the ring
// read until that load; a finished response may sit in the output register
// while the next request is accepted. After reset the WINDOW ring entries
// (800 by default) are cleared with ready low; csr writes are always taken.
module phase_accumulator_sliding_rms #(
   parameter int WINDOW      = 800,  // 1 .. 1024 samples
   parameter int PHASE_WIDTH = 32    // 8 .. 64 accumulator bits
) (
   input  logic                         clock,
   input  logic                         reset,
   pasr_req_if.sink                     req_chan,
   pasr_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [pasr_pkg::INC_W-1:0]   csr_wr_data
);

   // Sum of squares is exact: WINDOW * 2^30 fits SUM_W bits.
   localparam int SUM_W = $clog2(WINDOW + 1) + 30;
   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(pasr_pkg::ROOT_STEPS);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_SQRT   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

   // control
   logic [2:0]        state_ff, state_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [PTR_W-1:0]  clr_ff, clr_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [pasr_pkg::INC_W-1:0]       inc_ff, inc_in;
   logic [PHASE_WIDTH-1:0]           phase_acc_ff, phase_acc_in;
   logic [pasr_pkg::SQ_W-1:0]        sq_ff, sq_in;
   logic [SUM_W-1:0]                 sum_ff, sum_in;
   logic [pasr_pkg::SUB_W-1:0]       x_ff, x_in;        // sum - WINDOW * r^2
   logic [pasr_pkg::SUB_W-1:0]       root_ff, root_in;  // WINDOW * r * 2^(step+1)
   logic [pasr_pkg::RMS_W-1:0]       rms_acc_ff, rms_acc_in;
   logic [pasr_pkg::PHASE_OUT_W-1:0] rsp_phase_ff, rsp_phase_in;
   logic [pasr_pkg::RMS_W-1:0]       rsp_rms_ff, rsp_rms_in;

   // ring of squares
   logic [pasr_pkg::SQ_W-1:0] ring [WINDOW];
   logic [pasr_pkg::SQ_W-1:0] rd_data_ff;
   logic                      wr_en;
   logic [PTR_W-1:0]          wr_addr;
   logic [pasr_pkg::SQ_W-1:0] wr_data;

   // shared subtractor
   logic [pasr_pkg::SUB_W-1:0] sub_a, sub_b;
   pasr_pkg::sub_result_type   sub_res;

   logic                          req_fire;
   logic                          rsp_free;
   logic [pasr_pkg::SAMPLE_W:0]   sample_ext, mag;
   logic [2*pasr_pkg::SAMPLE_W+1:0] mag_sq;
   logic [SUM_W-1:0]              sum_new;
   logic [pasr_pkg::SUB_W-1:0]    root_bit;
   logic [63:0]                   phase_wide;

   pasr_sub_unit u_sub (
      .a      (sub_a),
      .b      (sub_b),
      .result (sub_res)
   );

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign req_fire           = req_chan.valid && req_chan.ready;
   assign rsp_free           = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.phase     = rsp_phase_ff;
   assign rsp_chan.rms_value = rsp_rms_ff;

   // |sample| fits 17 bits, its square 2^30 at most
   assign sample_ext = {req_chan.sample[pasr_pkg::SAMPLE_W-1], req_chan.sample};
   assign mag        = req_chan.sample[pasr_pkg::SAMPLE_W-1] ?
                       (~sample_ext + 1'b1) : sample_ext;
   assign mag_sq     = mag * mag;

   // new square enters the window
   assign sum_new    = sum_ff + SUM_W'(sq_ff);

   // square root: scaled bit = WINDOW * 4^step; trial term scaled likewise
   assign root_bit   = pasr_pkg::SUB_W'(WINDOW) << {step_ff, 1'b0};
   assign sub_a      = x_ff;
   assign sub_b      = root_ff + root_bit;

   assign phase_wide = 64'(phase_acc_ff);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      inc_in       = csr_wr_en ? csr_wr_data : inc_ff;
      phase_acc_in = phase_acc_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      x_in         = x_ff;
      root_in      = root_ff;
      rms_acc_in   = rms_acc_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_rms_in   = rsp_rms_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = sq_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == PTR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               phase_acc_in = phase_acc_ff + PHASE_WIDTH'(inc_ff);
               sq_in        = mag_sq[pasr_pkg::SQ_W-1:0];
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            // oldest square leaves the sum
            sum_in   = sum_ff - SUM_W'(rd_data_ff);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            sum_in     = sum_new;
            wr_en      = 1'b1;
            x_in       = pasr_pkg::SUB_W'(sum_new);
            root_in    = '0;
            rms_acc_in = '0;
            step_in    = CNT_W'(pasr_pkg::ROOT_STEPS - 1);
            ptr_in     = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
            state_in   = ST_SQRT;
         end
         ST_SQRT: begin
            // keep the bit if WINDOW * (r + 2^step)^2 still fits under the sum
            if (!sub_res.borrow) begin
               x_in       = sub_res.diff;
               root_in    = (root_ff >> 1) + root_bit;
               rms_acc_in = rms_acc_ff | (pasr_pkg::RMS_W'(1) << step_ff);
            end else begin
               root_in = root_ff >> 1;
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the response register to free up
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = phase_wide[pasr_pkg::PHASE_OUT_W-1:0];
               rsp_rms_in   = rms_acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         inc_ff       <= '0;
         phase_acc_ff <= '0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         inc_ff       <= inc_in;
         phase_acc_ff <= phase_acc_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff        <= sq_in;
      x_ff         <= x_in;
      root_ff      <= root_in;
      rms_acc_ff   <= rms_acc_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_rms_ff   <= rsp_rms_in;
   end

   // ring memory: one write port, registered read at the pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[wr_addr] <= wr_data;
      end
      rd_data_ff <= ring[ptr_ff];
   end

endmodule

// File: hdl/pasr_checker.sv
// Port-level assertions for the phase accumulator and RMS meter, bound to the top.
module pasr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [pasr_pkg::PHASE_OUT_W-1:0] rsp_phase,
   input logic [pasr_pkg::RMS_W-1:0]       rsp_rms_value
);

   // reset starts the ring clear: nothing pending, no request taken
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("response or ready after reset");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
                                  && $stable(rsp_rms_value))
      else $error("stalled response changed");

   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rms_value <= 16'd32768)
      else $error("rms above full scale");

endmodule

bind phase_accumulator_sliding_rms pasr_checker u_pasr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_phase     (rsp_chan.phase),
   .rsp_rms_value (rsp_chan.rms_value)
);

// File: tb/phase_accumulator_sliding_rms_checker.sv
// Checker: predicts phase and RMS readings from the request stream and compares responses.
`timescale 1ns / 100ps
module phase_accumulator_sliding_rms_checker #(
   parameter int WINDOW = 800
) (
   input  logic                       clock,
   input  logic                       reset,
   pasr_req_if                        req_chan,
   pasr_rsp_if                        rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [pasr_pkg::INC_W-1:0] csr_wr_data,
   output int                         mismatch_count,
   output int                         readings_seen,
   output int                         readings_waiting
);

   typedef struct packed {
      logic [pasr_pkg::PHASE_OUT_W-1:0] phase;
      logic [pasr_pkg::RMS_W-1:0]       rms_value;
   } meter_reading_type;

   logic [pasr_pkg::INC_W-1:0]       freq_word;
   logic [pasr_pkg::PHASE_OUT_W-1:0] phase_acc;
   logic [pasr_pkg::SQ_W-1:0]        square_ring [WINDOW];
   logic [40:0]                      square_sum;
   int                               ring_slot;
   meter_reading_type                readings_due [$];

   // bit-by-bit trial from the top; root never exceeds 2^15
   function automatic logic [pasr_pkg::RMS_W:0] floor_sqrt(input logic [40:0] value);
      logic [pasr_pkg::RMS_W:0] root;
      logic [pasr_pkg::RMS_W:0] trial;
      root = '0;
      for (int b = pasr_pkg::RMS_W; b >= 0; b--) begin
         trial = root | ((pasr_pkg::RMS_W+1)'(1) << b);
         if (64'(trial) * 64'(trial) <= 64'(value))
            root = trial;
      end
      return root;
   endfunction

   function automatic meter_reading_type advance_tick(
      input logic signed [pasr_pkg::SAMPLE_W-1:0] sample);
      logic signed [pasr_pkg::SAMPLE_W:0] wide;
      logic [pasr_pkg::SAMPLE_W:0]        magnitude;
      logic [pasr_pkg::SQ_W-1:0]          square;
      meter_reading_type                  reading;
      wide      = sample;
      magnitude = (wide < 0) ? -wide : wide;
      square    = pasr_pkg::SQ_W'(magnitude) * pasr_pkg::SQ_W'(magnitude);
      phase_acc = phase_acc + freq_word;
      // swap the oldest square out of the window
      square_sum = square_sum - square_ring[ring_slot] + square;
      square_ring[ring_slot] = square;
      ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
      reading.phase     = phase_acc;
      reading.rms_value = pasr_pkg::RMS_W'(floor_sqrt(square_sum / WINDOW));
      return reading;
   endfunction

   always @(posedge clock) begin
      meter_reading_type got;
      meter_reading_type want;
      int                errors;
      errors = 0;
      if (reset) begin
         freq_word  = '0;
         phase_acc  = '0;
         square_sum = '0;
         ring_slot  = 0;
         foreach (square_ring[i])
            square_ring[i] = '0;
         readings_due.delete();
         mismatch_count   <= 0;
         readings_seen    <= 0;
         readings_waiting <= 0;
      end else begin
         if (csr_wr_en)
            freq_word = csr_wr_data;
         // response first: it always belongs to an earlier request
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.phase     = rsp_chan.phase;
            got.rms_value = rsp_chan.rms_value;
            readings_seen <= readings_seen + 1;
            if (readings_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual phase %h rms %0d",
                        $time, got.phase, got.rms_value);
               errors++;
            end else begin
               want = readings_due.pop_front();
               if (got.phase !== want.phase) begin
                  $display("%0t: phase mismatch, expected %h, actual %h",
                           $time, want.phase, got.phase);
                  errors++;
               end
               if (got.rms_value !== want.rms_value) begin
                  $display("%0t: rms_value mismatch, expected %0d, actual %0d",
                           $time, want.rms_value, got.rms_value);
                  errors++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            readings_due.push_back(advance_tick(req_chan.sample));
         mismatch_count   <= mismatch_count + errors;
         readings_waiting <= readings_due.size();
      end
   end

endmodule

// File: tb/phase_accumulator_sliding_rms_test.sv
// Testbench top: drives samples and frequency words into the phase/RMS meter and gives the verdict.
`timescale 1ns / 100ps
module phase_accumulator_sliding_rms_test;

   localparam int WINDOW          = 800;
   localparam int HOLD_OFF_CYCLES = 400;  // long enough to back the block up fully

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       csr_wr_en;
   logic [pasr_pkg::INC_W-1:0] csr_wr_data;
   logic                       hold_toggle = 1'b0;  // flipped to start a long receiver hold-off

   int req_idle_pct  = 0;  // chance per cycle that the sender leaves a gap
   int rsp_stall_pct = 0;  // chance per cycle that the receiver drops ready
   int sent_count    = 0;  // requests accepted so far

   int mismatch_count;
   int readings_seen;
   int readings_waiting;

   pasr_req_if req_chan ();
   pasr_rsp_if rsp_chan ();

   phase_accumulator_sliding_rms #(.WINDOW(WINDOW)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   phase_accumulator_sliding_rms_checker #(.WINDOW(WINDOW)) reading_check (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .readings_seen    (readings_seen),
      .readings_waiting (readings_waiting)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("phase_accumulator_sliding_rms test failed");
      $finish;
   end

   // Receiver: random stalls at rsp_stall_pct, plus a long hold-off whenever
   // hold_toggle flips. The hold-off is counted here so the sender keeps going.
   initial begin : rsp_sink
      logic seen_toggle;
      int   hold_left;
      seen_toggle = 1'b0;
      hold_left   = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left   = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Mix of full-range noise, corner values, small signals and near full scale
   // of either sign.
   function automatic logic signed [pasr_pkg::SAMPLE_W-1:0] random_sample();
      int value;
      case ($urandom_range(9))
         0, 1, 2, 3: value = int'($urandom_range(65535)) - 32768;
         4: begin
            case ($urandom_range(3))
               0:       value = -32768;
               1:       value = 32767;
               2:       value = -1;
               default: value = 0;
            endcase
         end
         5, 6: value = int'($urandom_range(511)) - 256;
         default: begin
            value = 32767 - int'($urandom_range(2047));
            if ($urandom_range(1) == 1)
               value = -value - 1;
         end
      endcase
      return pasr_pkg::SAMPLE_W'(value);
   endfunction

   // One request. A random gap (at req_idle_pct) goes in front of it; valid
   // and the sample then hold until the block takes them.
   task automatic offer_sample(input logic signed [pasr_pkg::SAMPLE_W-1:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct)
         gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= value;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sent_count++;
   endtask

   task automatic offer_random(input int count);
      repeat (count) offer_sample(random_sample());
   endtask

   // Stop sending and wait until every request has its response back.
   // Every request yields exactly one response, so the block is idle after.
   task automatic wait_for_readings();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (readings_seen != sent_count)
         @(posedge clock);
   endtask

   // Frequency word write; only called while the block is idle.
   task automatic write_freq_word(input logic [pasr_pkg::INC_W-1:0] word);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= word;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      // zero, both full-scale ends, +/-1, alternating bit patterns, small values
      int corners [20];
      corners = '{0, -32768, 32767, -1, 1, 0,
                  -32768, -32768, -32768, 32767, 32767, 16384, -16384,
                  21845, -21846, 255, -256, 181, -182, 0};

      req_chan.valid  <= 1'b0;
      req_chan.sample <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: first with the reset frequency word (phase stays at 0),
      // then with all ones so the phase counts down by one every tick.
      // The block is still clearing its ring right after reset; the first
      // request just waits for ready.
      for (int i = 0; i < 6; i++)
         offer_sample(pasr_pkg::SAMPLE_W'(corners[i]));
      wait_for_readings();
      write_freq_word(32'hFFFF_FFFF);
      for (int i = 6; i < 20; i++)
         offer_sample(pasr_pkg::SAMPLE_W'(corners[i]));
      wait_for_readings();

      // No idling. Receiver holds off for a long stretch while the sender
      // keeps pushing, so the block backs up and stalls req ready.
      // A full window of the most negative sample drives the sum to its
      // maximum and the RMS to exactly 32768.
      write_freq_word(32'h8000_0000);
      hold_toggle <= ~hold_toggle;
      repeat (WINDOW + 10) offer_sample(pasr_pkg::SAMPLE_W'(-32768));
      offer_random(20);
      wait_for_readings();

      // Sender mostly idle, with a full drain halfway through.
      write_freq_word($urandom);
      req_idle_pct = 84;
      offer_random(150);
      wait_for_readings();
      offer_random(150);
      wait_for_readings();

      // Receiver mostly stalling; smallest nonzero frequency word.
      write_freq_word(32'h0000_0001);
      req_idle_pct = 0;
      rsp_stall_pct <= 84;
      offer_random(300);
      wait_for_readings();

      // Both sides idle now and then; frequency word back to zero, then max.
      write_freq_word('0);
      req_idle_pct = 24;
      rsp_stall_pct <= 24;
      offer_random(150);
      wait_for_readings();
      write_freq_word(32'hFFFF_FFFF);
      offer_random(150);
      wait_for_readings();

      // let anything stray come out before the verdict
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && readings_waiting == 0)
         $display("phase_accumulator_sliding_rms test passed");
      else
         $display("phase_accumulator_sliding_rms test failed");
      $finish;
   end

endmodule

// File: phase_accumulator_sliding_rms.f
hdl/pasr_pkg.sv
hdl/pasr_req_if.sv
hdl/pasr_rsp_if.sv
hdl/pasr_sub_unit.sv
hdl/phase_accumulator_sliding_rms.sv
hdl/pasr_checker.sv
tb/phase_accumulator_sliding_rms_checker.sv
tb/phase_accumulator_sliding_rms_test.sv
